### sv/tks_pkg.sv
// Shared constants, types and helpers for the table key search block.
// Used by tks_search and table_key_search; depends on nothing.
package tks_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ENTRY_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = ADDR_W + 2;
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 10;
    localparam int POS_W       = 10;
    localparam int VALUE_W     = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_SEARCH_MODE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } t_state;

    typedef struct packed {
        logic                   start;
        logic                   mode;
        logic [CNT_W-1:0]       count;
        logic [ENTRY_WIDTH-1:0] key;
    } t_search_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    function automatic logic [ENTRY_WIDTH-1:0] to_entry(input logic [VALUE_W-1:0] v);
        logic [VALUE_W+63:0] ext;
        ext = {{64{v[VALUE_W-1]}}, v};
        return ext[ENTRY_WIDTH-1:0];
    endfunction

endpackage

### sv/tks_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; depends on nothing.
module tks_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/tks_search.sv
// Search sequencer: one probe at a time through a shared signed comparator.
// Depends on tks_pkg; reads the table through the read port of tks_ram.
module tks_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tks_pkg::t_search_req            i_req,
    output logic                            o_busy,
    output tks_pkg::t_rd_req                o_rd,
    input  logic [tks_pkg::ENTRY_WIDTH-1:0] i_rd_data,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [tks_pkg::POS_W-1:0]       o_position
);
    import tks_pkg::*;

    t_state r_state, n_state;
    logic                          r_mode, n_mode;
    logic [ADDR_W:0]               r_cnt, n_cnt;
    logic [ENTRY_WIDTH-1:0]        r_key, n_key;
    logic signed [PTR_W-1:0]       r_lo, n_lo;
    logic signed [PTR_W-1:0]       r_hi, n_hi;
    logic [ADDR_W-1:0]             r_mid, n_mid;
    logic                          r_valid, n_valid;
    logic                          r_found, n_found;
    logic [POS_W-1:0]              r_pos, n_pos;

    logic [ADDR_W:0]               cnt_sat;
    logic signed [PTR_W-1:0]       mid_b;
    logic                          empty;
    logic                          cmp_eq;
    logic                          cmp_lt;

    assign cnt_sat = (32'(i_req.count) > TABLE_DEPTH) ? (ADDR_W+1)'(TABLE_DEPTH)
                                                       : (ADDR_W+1)'(i_req.count);
    assign mid_b   = r_lo + ((r_hi - r_lo) >>> 1);
    assign empty   = (r_mode == MODE_BINARY) ? (r_lo > r_hi)
                                             : (r_lo >= $signed(PTR_W'(r_cnt)));
    assign cmp_eq  = (i_rd_data == r_key);
    assign cmp_lt  = ($signed(i_rd_data) < $signed(r_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_cnt   <= n_cnt;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_key   = r_key;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_valid = 1'b0;
        n_found = r_found;
        n_pos   = r_pos;
        o_rd.en   = 1'b0;
        o_rd.addr = r_mid;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_mode  = i_req.mode;
                    n_cnt   = cnt_sat;
                    n_key   = i_req.key;
                    n_lo    = '0;
                    n_hi    = $signed(PTR_W'(cnt_sat)) - PTR_W'(1);
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (empty) begin
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_mid     = (r_mode == MODE_BINARY) ? mid_b[ADDR_W-1:0]
                                                        : r_lo[ADDR_W-1:0];
                    o_rd.en   = 1'b1;
                    o_rd.addr = n_mid;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp_eq) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_mid);
                    n_state = S_IDLE;
                end else begin
                    if (r_mode == MODE_BINARY && !cmp_lt) begin
                        n_hi = $signed(PTR_W'(r_mid)) - PTR_W'(1);
                    end else begin
                        n_lo = $signed(PTR_W'(r_mid)) + PTR_W'(1);
                    end
                    n_state = S_PROBE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

### sv/table_key_search.sv
// Top level of the table key search block: configuration registers, table RAM
// and search sequencer. Depends on tks_pkg, tks_ram and tks_search.
//
// Requests enter on i_start with i_kind, i_entry_index and i_value and are
// taken at a clock edge where i_start is high and o_busy is low.
// A load request (kind 0) writes one table entry at that edge; it gives no
// result and does not raise o_busy, so loads can follow every cycle.
// A query request (kind 1) raises o_busy until its single result has been
// registered. Each probe reads the table RAM in state S_PROBE and then
// compares its registered output with the key in state S_CMP. The result
// strobe o_valid is registered from S_CMP for a hit and from S_PROBE for a
// miss, also for an empty table. Binary mode needs at most 11 probes at
// full depth; linear mode needs up to the entry count.
// o_valid is high for exactly one cycle; o_found and o_position hold until
// the next result; the receiver cannot stall them. A new request may be
// accepted in the cycle in which the result is shown.
// Reset clears the registers to linear mode and an empty table count and
// ends any search in progress; the table content is undefined until written.
// Configuration is written over the APB port while the block is idle: this
// binds the user, and the block itself does not enforce it.
module table_key_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tks_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tks_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tks_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_kind,
    input  logic [tks_pkg::IDX_W-1:0]       i_entry_index,
    input  logic signed [tks_pkg::VALUE_W-1:0] i_value,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [tks_pkg::POS_W-1:0]       o_position
);
    import tks_pkg::*;

    logic [CNT_W-1:0]       r_entry_count;
    logic                   r_search_mode;
    logic                   cfg_wr;
    logic                   reg_sel;
    logic                   accept;
    logic                   wr_en;
    logic [ENTRY_WIDTH-1:0] entry_val;
    logic [ENTRY_WIDTH-1:0] rd_data;
    t_search_req            req;
    t_rd_req                rd;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_search_mode <= MODE_LINEAR;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ENTRY_COUNT: r_entry_count <= pwdata[CNT_W-1:0];
                REG_SEARCH_MODE: r_search_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ENTRY_COUNT: prdata = APB_DATA_W'(r_entry_count);
            REG_SEARCH_MODE: prdata = APB_DATA_W'(r_search_mode);
            default:         prdata = '0;
        endcase
    end

    assign accept    = i_start && !o_busy;
    assign entry_val = to_entry(i_value);
    assign wr_en     = accept && (i_kind == KIND_LOAD) && (32'(i_entry_index) < TABLE_DEPTH);

    assign req.start = accept && (i_kind == KIND_QUERY);
    assign req.mode  = r_search_mode;
    assign req.count = r_entry_count;
    assign req.key   = entry_val;

    tks_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_WIDTH),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(i_entry_index)),
        .i_wr_data (entry_val),
        .i_rd_en   (rd.en),
        .i_rd_addr (rd.addr),
        .o_rd_data (rd_data)
    );

    tks_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_busy     (o_busy),
        .o_rd       (rd),
        .i_rd_data  (rd_data),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_position (o_position)
    );

endmodule
